// ===== hdl/sdf_pkg.sv =====
// Package for the schema digest block: FNV-1a 64-bit constants and shared types.
// Used by the round unit and by the top level.
`default_nettype none

package sdf_pkg;

   localparam int unsigned HashWidth  = 64;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 32;

   // The FNV prime is 2^40 + 0x1B3, so the product splits into a shift and a
   // narrow constant multiply.
   localparam int unsigned PrimeShift    = 40;
   localparam int unsigned PrimeLowWidth = 9;
   localparam logic [PrimeLowWidth-1:0] PrimeLow = 9'h1B3;

   localparam logic [HashWidth-1:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

   localparam int unsigned BytesPerWord = WordWidth / ByteWidth;
   localparam int unsigned ByteCntWidth = $clog2(BytesPerWord);
   localparam logic [ByteCntWidth-1:0] LastByte = ByteCntWidth'(BytesPerWord - 1);

   typedef logic [HashWidth-1:0] hash_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ROUND  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/sdf_fnv_round.sv =====
// One FNV-1a round: xor a byte into the hash, then multiply by the prime mod 2^64.
// Depends on sdf_pkg for the prime split and widths.
`default_nettype none

module sdf_fnv_round
   import sdf_pkg::*;
(
   input  wire hash_type               hash_in,
   input  wire logic [ByteWidth-1:0]   byte_in,
   output hash_type                    hash_out
);

   hash_type                                 mixed;
   logic [HashWidth+PrimeLowWidth-1:0]       low_prod;
   hash_type                                 high_part;

   always_comb begin
      mixed     = hash_in ^ {{(HashWidth-ByteWidth){1'b0}}, byte_in};
      low_prod  = {{PrimeLowWidth{1'b0}}, mixed} * {{HashWidth{1'b0}}, PrimeLow};
      high_part = {mixed[HashWidth-PrimeShift-1:0], {PrimeShift{1'b0}}};
      hash_out  = high_part + low_prod[HashWidth-1:0];
   end

endmodule

`default_nettype wire

// ===== hdl/schema_digest_fnv1a_sum_top.sv =====
// Order-independent FNV-1a 64 digest over a stream of type-record words.
// Each item passes ST_IDLE (accept), ST_ROUND (four rounds of the shared byte unit, one byte
// per cycle, least significant first) and ST_FINISH, which on a record's last word folds the
// hash into the digest, then loads the result register; ST_FINISH waits while an earlier
// result is still stalled. Synchronous active-high reset: hash to the offset basis,
// digest and count to 0. Depends on sdf_pkg and sdf_fnv_round.
`default_nettype none

module schema_digest_fnv1a_sum_top
   import sdf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [WordWidth-1:0]   req_word,
   input  wire logic                   req_last_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [HashWidth-1:0]        rsp_digest,
   output logic [CountWidth-1:0]       rsp_type_total
);

   state_type                 state_ff, state_in;
   logic [WordWidth-1:0]      word_ff, word_in;
   logic                      last_ff, last_in;
   logic [ByteCntWidth-1:0]   byte_cnt_ff, byte_cnt_in;
   hash_type                  hash_ff, hash_in;
   hash_type                  digest_ff, digest_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   hash_type                  rsp_digest_ff, rsp_digest_in;
   logic [CountWidth-1:0]     rsp_count_ff, rsp_count_in;

   hash_type                  round_hash;
   logic                      finish_fire;

   sdf_fnv_round u_round (
      .hash_in  (hash_ff),
      .byte_in  (word_ff[ByteWidth-1:0]),
      .hash_out (round_hash)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digest     = rsp_digest_ff;
   assign rsp_type_total = rsp_count_ff;

   // The result register may be reloaded once the previous item has been taken.
   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      byte_cnt_in   = byte_cnt_ff;
      hash_in       = hash_ff;
      digest_in     = digest_ff;
      count_in      = count_ff;
      rsp_digest_in = rsp_digest_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in     = req_word;
               last_in     = req_last_word;
               byte_cnt_in = '0;
               state_in    = ST_ROUND;
            end
         end
         ST_ROUND: begin
            hash_in     = round_hash;
            word_in     = {{ByteWidth{1'b0}}, word_ff[WordWidth-1:ByteWidth]};
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (byte_cnt_ff == LastByte) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_fire) begin
               if (last_ff) begin
                  digest_in     = digest_ff + hash_ff;
                  count_in      = count_ff + 1'b1;
                  hash_in       = FnvBasis;
                  rsp_digest_in = digest_ff + hash_ff;
                  rsp_count_in  = count_ff + 1'b1;
               end else begin
                  rsp_digest_in = digest_ff;
                  rsp_count_in  = count_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_cnt_ff  <= '0;
         hash_ff      <= FnvBasis;
         digest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         hash_ff      <= hash_in;
         digest_ff    <= digest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      last_ff       <= last_in;
      rsp_digest_ff <= rsp_digest_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for schema_digest_fnv1a_sum_top: streams type-record words and
// checks every digest and record count against an FNV-1a 64 sum predictor.
// Depends on sdf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top
   import sdf_pkg::*;
();

   localparam hash_type FoldPrime     = 64'h0000_0100_0000_01B3;
   localparam int       WatchdogLimit = 5000;
   localparam int       TailCycles    = 40;

   typedef struct packed {
      hash_type              digest;
      logic [CountWidth-1:0] type_total;
   } digest_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [WordWidth-1:0]  req_word;
   logic                  req_last_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   hash_type              rsp_digest;
   logic [CountWidth-1:0] rsp_type_total;

   // Predictor state, advanced once per accepted item.
   hash_type              open_hash;
   hash_type              digest_total;
   logic [CountWidth-1:0] records_closed;

   digest_report_type pending_reports[$];

   int error_count;
   int items_sent;
   int reports_checked;
   int quiet_cycles;
   int burst_left;
   bit steady_send;
   int hold_request;
   int longest_hold;

   schema_digest_fnv1a_sum_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digest     (rsp_digest),
      .rsp_type_total (rsp_type_total)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic hash_type fold_word(hash_type h, logic [WordWidth-1:0] w);
      for (int k = 0; k < BytesPerWord; k++) begin
         h = (h ^ hash_type'(w[ByteWidth*k +: ByteWidth])) * FoldPrime;
      end
      return h;
   endfunction

   function automatic void advance_digest(logic [WordWidth-1:0] w, logic last);
      digest_report_type report;
      open_hash = fold_word(open_hash, w);
      if (last) begin
         digest_total   = digest_total + open_hash;
         records_closed = records_closed + 1'b1;
         open_hash      = FnvBasis;
      end
      report.digest     = digest_total;
      report.type_total = records_closed;
      pending_reports.insert(pending_reports.size(), report);
   endfunction

   // Mostly uniform words, with all-zero, all-one and single-byte patterns mixed in.
   function automatic logic [WordWidth-1:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return '0;
         1: return '1;
         2: return WordWidth'(8'hFF) << (ByteWidth * $urandom_range(0, BytesPerWord - 1));
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [WordWidth-1:0] w, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_send ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_word      <= w;
      req_last_word <= last;
      do @(posedge clock); while (req_stall);
      advance_digest(w, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // A record: type id, version, size, alignment, then four words per field.
   task automatic send_record(input int field_total);
      int length;
      logic [WordWidth-1:0] w;
      length = 4 + 4 * field_total;
      for (int i = 0; i < length; i++) begin
         case (i)
            0: w = $urandom;
            1: w = $urandom_range(0, 15);
            2: w = random_word();
            3: w = WordWidth'(1) << $urandom_range(0, 6);
            default: w = random_word();
         endcase
         send_item(w, i == length - 1);
      end
   endtask

   task automatic test_directed();
      steady_send = 1'b0;
      send_item('0, 1'b1);
      send_item('1, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'hFFFF_FFFE, 1'b1);
      send_item('0, 1'b0);
      send_item('1, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0001, 1'b1);
      // An open record must not show in the digest until its last word arrives.
      send_item(32'h1234_5678, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h5555_5555, 1'b1);
      send_item(32'h0000_00FF, 1'b0);
      send_item(32'h0000_FF00, 1'b0);
      send_item(32'h00FF_0000, 1'b0);
      send_item(32'hFF00_0000, 1'b1);
      // A two-word record, then one with the same two words in swapped order.
      send_item(32'h0102_0304, 1'b0);
      send_item(32'h0506_0708, 1'b1);
      send_item(32'h0506_0708, 1'b0);
      send_item(32'h0102_0304, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_records(input int item_goal);
      int goal;
      goal = items_sent + item_goal;
      while (items_sent < goal) begin
         if ($urandom_range(0, 7) == 0) steady_send = ~steady_send;
         if ($urandom_range(0, 15) == 0) send_record($urandom_range(4, 8));
         else send_record($urandom_range(0, 3));
      end
      steady_send = 1'b0;
      wait_for_drain();
   endtask

   // Random words with a random end flag: single-word records and broken records.
   task automatic test_noise(input int item_count);
      for (int i = 0; i < item_count; i++) begin
         send_item(random_word(), 1'($urandom_range(0, 1)));
      end
      wait_for_drain();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      steady_send  = 1'b1;
      hold_request = 300;
      @(negedge clock);
      for (int i = 0; i < 40; i++) begin
         send_item(random_word(), $urandom_range(0, 3) == 0);
      end
      steady_send = 1'b0;
      wait_for_drain();
   endtask

   // The sender stops between small groups until every result is back.
   task automatic test_drain_pause();
      for (int g = 0; g < 6; g++) begin
         for (int i = 0; i < $urandom_range(1, 5); i++) begin
            send_item(random_word(), 1'($urandom_range(0, 1)));
         end
         wait_for_drain();
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Receiver stall pattern: free-running, random, periodic or heavy,
   // switching now and then, plus a long hold-off on request.
   initial begin
      int hold_left;
      int stall_mode;
      int mode_left;
      int phase;
      int period;
      hold_left  = 0;
      stall_mode = 0;
      mode_left  = 0;
      phase      = 0;
      period     = 4;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            longest_hold = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
            period     = $urandom_range(2, 9);
         end
         mode_left--;
         phase = (phase + 1) % period;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= (phase < period / 2);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      digest_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result with nothing expected: digest %h type_total %0d",
                     $time, rsp_digest, rsp_type_total);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_digest !== want.digest) begin
               $display("%0t: digest mismatch: expected %h actual %h",
                        $time, want.digest, rsp_digest);
               error_count++;
            end
            if (rsp_type_total !== want.type_total) begin
               $display("%0t: type_total mismatch: expected %0d actual %0d",
                        $time, want.type_total, rsp_type_total);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, WatchdogLimit, pending_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_word        = '0;
      req_last_word   = 1'b0;
      open_hash       = FnvBasis;
      digest_total    = '0;
      records_closed  = '0;
      error_count     = 0;
      items_sent      = 0;
      reports_checked = 0;
      quiet_cycles    = 0;
      burst_left      = 0;
      steady_send     = 1'b0;
      hold_request    = 0;
      longest_hold    = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random_records(1500);
      test_noise(350);

      wait_for_drain();
      repeat (TailCycles) @(posedge clock);
      $display("Sent %0d items closing %0d records; %0d results checked field by field.",
               items_sent, records_closed, reports_checked);
      $display("Included open records, byte extremes, and a %0d-cycle receiver hold-off.",
               longest_hold);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
